// File: rtl/core/dtpb_pkg.sv
package dtpb_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_DECIDE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the accepted item
        logic retire;   // pop the head entry
        logic decide;   // drop or append, write the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic can_retire;   // head entry finishes at or before the arrival
        logic out_free;     // result register can take a new result
    } t_status;

endpackage

// File: rtl/core/dtpb_in_if.sv
interface dtpb_in_if;
    logic                       valid;
    logic                       ready;
    logic [dtpb_pkg::TIME_W-1:0] arrival_time;
    logic [dtpb_pkg::TIME_W-1:0] processing_time;

    modport source (output valid, output arrival_time, output processing_time, input ready);
    modport sink   (input valid, input arrival_time, input processing_time, output ready);
endinterface

// File: rtl/core/dtpb_out_if.sv
interface dtpb_out_if;
    logic                       valid;
    logic                       ready;
    logic                       dropped;
    logic [dtpb_pkg::TIME_W-1:0] start_time;

    modport source (output valid, output dropped, output start_time, input ready);
    modport sink   (input valid, input dropped, input start_time, output ready);
endinterface

// File: rtl/core/dtpb_ctrl.sv
module dtpb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dtpb_pkg::t_status i_status,
    output dtpb_pkg::t_cmd    o_cmd
);
    import dtpb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.can_retire) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_LOAD: begin
            end
            S_CHECK: begin
                o_cmd.retire = i_status.can_retire;
            end
            S_DECIDE: begin
                o_cmd.decide = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/dtpb_dp.sv
module dtpb_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtpb_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [dtpb_pkg::TIME_W-1:0]   i_arrival_time,
    input  logic [dtpb_pkg::TIME_W-1:0]   i_processing_time,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_dropped,
    output logic [dtpb_pkg::TIME_W-1:0]   o_start_time,
    input  dtpb_pkg::t_cmd                i_cmd,
    output dtpb_pkg::t_status             o_status
);
    import dtpb_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

    logic [TIME_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]  r_buffer_size;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [OCC_W-1:0]  r_occ;
    logic              r_out_valid;
    logic [TIME_W-1:0] r_arrival;
    logic [TIME_W-1:0] r_proc;
    logic [TIME_W-1:0] r_last_finish;
    logic [TIME_W-1:0] r_rd_data;
    logic              r_dropped;
    logic [TIME_W-1:0] r_start_time;

    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;
    logic [IDX_W-1:0]  rd_addr;
    logic [CMP_W-1:0]  capacity;
    logic              full;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] finish;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    // read ahead so the registered head entry tracks the head pointer
    assign rd_addr  = i_cmd.retire ? head_inc : r_head;

    assign capacity = (CMP_W'(r_buffer_size) > DEPTH_C) ? DEPTH_C : CMP_W'(r_buffer_size);
    assign full     = CMP_W'(r_occ) >= capacity;
    assign start    = (r_occ == '0) ? r_arrival : r_last_finish;
    assign sum      = {1'b0, start} + {1'b0, r_proc};
    assign finish   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    assign o_status.can_retire = (r_occ != '0) && (r_rd_data <= r_arrival);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= CFG_RESET;
            r_head        <= '0;
            r_tail        <= '0;
            r_occ         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buffer_size <= i_cfg_wdata;
            end
            if (i_cmd.retire) begin
                r_head <= head_inc;
                r_occ  <= r_occ - 1'b1;
            end else if (i_cmd.decide && !full) begin
                r_tail <= tail_inc;
                r_occ  <= r_occ + 1'b1;
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if (i_cmd.decide && !full) begin
            mem[r_tail] <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_arrival <= i_arrival_time;
            r_proc    <= i_processing_time;
        end
        if (i_cmd.decide) begin
            r_dropped    <= full;
            r_start_time <= full ? '0 : start;
            if (!full) begin
                r_last_finish <= finish;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dropped    = r_dropped;
    assign o_start_time = r_start_time;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_occ) <= DEPTH_C)
        else $error("occupancy above depth");

    a_retire_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.retire |-> (r_occ != '0))
        else $error("retire on empty buffer");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending result");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && !full) |=> (r_occ == $past(r_occ) + 1'b1))
        else $error("append did not grow occupancy");

endmodule

// File: rtl/core/drop_tail_packet_buffer_sim_unit.sv
// Drop-tail packet buffer: one processor behind a FIFO of finish times. Each
// input item carries an arrival time and a processing time and yields one
// result item (dropped flag, start time; start time is 0 when dropped). An
// item goes through load, check and decide; check retires head finish times
// one entry per cycle via the single read port of the finish-time memory.
// The result sits in an output register, so the next item is taken while a
// result waits; it then stalls in its last step only if the previous result
// is still not taken. buffer_size is written through i_cfg_we/i_cfg_wdata;
// the user must do so only while idle, unchecked by the block. Values above
// DEPTH act as DEPTH, zero drops every packet. No clearing pass after reset.
module drop_tail_packet_buffer_sim_unit #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dtpb_pkg::CFG_W-1:0] i_cfg_wdata,
    dtpb_in_if.sink                    i_in,
    dtpb_out_if.source                 o_out
);
    import dtpb_pkg::*;

    t_cmd    cmd;
    t_status status;

    dtpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dtpb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_arrival_time    (i_in.arrival_time),
        .i_processing_time (i_in.processing_time),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_dropped         (o_out.dropped),
        .o_start_time      (o_out.start_time),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule
